// File: design/wts_pkg.sv
// shared types and constants for the weekly time switch table
// no dependencies
`default_nettype none

package wts_pkg;

    typedef enum logic [1:0] {
        CMD_SCAN   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [3:0] EVERY_DAY   = 4'd8;
    localparam logic [3:0] ALL_OUTPUTS = 4'd5;

    typedef struct packed {
        logic [3:0] day;
        logic [3:0] target;
        logic       turn_on;
        logic [6:0] hour;
        logic [6:0] minute;
    } t_entry;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
    } t_now;

endpackage

`default_nettype wire

// File: design/wts_entry_ram.sv
// entry store: single write port, single registered read port
// depends on wts_pkg
`default_nettype none

module wts_entry_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire wts_pkg::t_entry  i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output wts_pkg::t_entry       o_rd_data
);

    wts_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/wts_match.sv
// compares one stored entry against the scan time and applies it to the outputs
// depends on wts_pkg
`default_nettype none

module wts_match (
    input  wire wts_pkg::t_entry i_entry,
    input  wire wts_pkg::t_now   i_now,
    input  wire logic [3:0]      i_outputs,
    output logic [3:0]           o_outputs
);

    logic       time_hit;
    logic       day_hit;
    logic [3:0] mask;

    always_comb begin
        time_hit = (i_entry.hour == {2'b00, i_now.hour})
                && (i_entry.minute == {1'b0, i_now.minute});
        day_hit  = (i_entry.day == {1'b0, i_now.weekday})
                || (i_entry.day == wts_pkg::EVERY_DAY);
        case (i_entry.target)
            4'd1:    mask = 4'b0001;
            4'd2:    mask = 4'b0010;
            4'd3:    mask = 4'b0100;
            4'd4:    mask = 4'b1000;
            4'd5:    mask = 4'b1111;
            default: mask = 4'b0000;
        endcase
        if (!(time_hit && day_hit)) begin
            o_outputs = i_outputs;
        end else if (i_entry.turn_on) begin
            o_outputs = i_outputs | mask;
        end else begin
            o_outputs = i_outputs & ~mask;
        end
    end

endmodule

`default_nettype wire

// File: design/weekly_time_switch_table_unit.sv
// add, toggle, clear and a scan of an empty table answer in the cycle after the beat; a scan
// otherwise reads each stored entry, one memory read per entry per cycle, then answers
// throughput: one command at a time, next beat taken once the result register frees
// reset: fill count, outputs and handshake cleared at once; no clearing pass
// depends on wts_pkg, wts_entry_ram, wts_match
`default_nettype none

module weekly_time_switch_table_unit #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [4:0] i_cur_hour,
    input  wire logic [5:0] i_cur_minute,
    input  wire logic [2:0] i_cur_weekday,
    input  wire logic [3:0] i_entry_day,
    input  wire logic [3:0] i_entry_output,
    input  wire logic       i_entry_turn_on,
    input  wire logic [6:0] i_entry_hour,
    input  wire logic [6:0] i_entry_minute,
    input  wire logic [1:0] i_toggle_select,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [3:0]      o_output_bits,
    output logic            o_status
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_issue_idx;
    logic            r_rd_valid;
    logic [3:0]      r_outputs;
    logic            r_out_valid;
    logic [3:0]      r_out_bits;
    logic            r_status;
    wts_pkg::t_now   r_now;

    wts_pkg::t_cmd   cmd;
    wts_pkg::t_entry new_entry;
    wts_pkg::t_entry rd_entry;
    logic            in_acc;
    logic            table_full;
    logic            wr_en;
    logic            rd_en;
    logic [3:0]      n_outputs;
    logic [3:0]      toggled;

    assign o_in_ready    = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid   = r_out_valid;
    assign o_output_bits = r_out_bits;
    assign o_status      = r_status;

    always_comb begin
        cmd        = wts_pkg::t_cmd'(i_command);
        in_acc     = i_in_valid && o_in_ready;
        table_full = (r_count == CW'(TABLE_ENTRIES));
        wr_en      = in_acc && (cmd == wts_pkg::CMD_ADD) && !table_full;
        rd_en      = (r_state == S_SCAN) && (r_issue_idx != r_count);
        toggled    = r_outputs ^ (4'b0001 << i_toggle_select);
        new_entry.day     = i_entry_day;
        new_entry.target  = i_entry_output;
        new_entry.turn_on = i_entry_turn_on;
        new_entry.hour    = i_entry_hour;
        new_entry.minute  = i_entry_minute;
    end

    wts_entry_ram #(
        .DEPTH(TABLE_ENTRIES),
        .AW   (AW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(new_entry),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_issue_idx[AW-1:0]),
        .o_rd_data(rd_entry)
    );

    wts_match u_match (
        .i_entry  (rd_entry),
        .i_now    (r_now),
        .i_outputs(r_outputs),
        .o_outputs(n_outputs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue_idx <= '0;
            r_rd_valid  <= 1'b0;
            r_outputs   <= 4'b0000;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_out_bits <= r_outputs;
                        r_status   <= 1'b0;
                        unique case (cmd)
                            wts_pkg::CMD_SCAN: begin
                                r_now.hour    <= i_cur_hour;
                                r_now.minute  <= i_cur_minute;
                                r_now.weekday <= i_cur_weekday;
                                r_issue_idx   <= '0;
                                r_rd_valid    <= 1'b0;
                                if (r_count == '0) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            wts_pkg::CMD_ADD: begin
                                if (!table_full) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_status    <= table_full;
                                r_out_valid <= 1'b1;
                            end
                            wts_pkg::CMD_TOGGLE: begin
                                r_outputs   <= toggled;
                                r_out_bits  <= toggled;
                                r_out_valid <= 1'b1;
                            end
                            wts_pkg::CMD_CLEAR: begin
                                r_count     <= '0;
                                r_out_valid <= 1'b1;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rd_valid <= rd_en;
                    if (rd_en) begin
                        r_issue_idx <= r_issue_idx + CW'(1);
                    end
                    if (r_rd_valid) begin
                        r_outputs <= n_outputs;
                    end
                    if (!rd_en && !r_rd_valid) begin
                        r_out_bits  <= r_outputs;
                        r_status    <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/wts_checker.sv
// port-level checks for the weekly time switch table, bound to the top level
// depends on wts_pkg and weekly_time_switch_table_unit
`default_nettype none

module wts_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [1:0] i_command,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] o_output_bits,
    input wire logic       o_status
);

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_output_bits)
            && $stable(o_status))
        else $error("result dropped or changed while stalled");

    a_no_take_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("beat taken while result waits");

    a_short_cmd_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_command == wts_pkg::CMD_TOGGLE || i_command == wts_pkg::CMD_CLEAR)
            |=> o_out_valid && !o_status)
        else $error("toggle or clear did not answer next cycle with status done");

    a_add_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_command == wts_pkg::CMD_ADD |=> o_out_valid)
        else $error("add did not answer next cycle");

endmodule

bind weekly_time_switch_table_unit wts_checker u_wts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_command    (i_command),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_output_bits(o_output_bits),
    .o_status     (o_status)
);

`default_nettype wire
